FILE: src/multi_button_debouncer_macros.svh
// Assertion macros for the multi-button debouncer checker
`ifndef MULTI_BUTTON_DEBOUNCER_MACROS_SVH
`define MULTI_BUTTON_DEBOUNCER_MACROS_SVH

// same-cycle implication
`define MBD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/mbd_pkg.sv
// Shared types and constants of the multi-button debouncer
package mbd_pkg;

	localparam int RAW_WIDTH = 4;
	localparam int IDX_WIDTH = 2;
	localparam int CNT_WIDTH = 8;
	localparam int DUR_WIDTH = 16;
	localparam int CFG_WIDTH = 16;
	localparam int REG_IDX_WIDTH = 2;

	localparam int DEF_BUTTON_COUNT = 4;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam logic [CNT_WIDTH-1:0] STABLE_RESET = 8'd20;
	localparam logic [DUR_WIDTH-1:0] SHORT_RESET = 16'd60;
	localparam logic [DUR_WIDTH-1:0] LONG_RESET = 16'd400;

	localparam logic [REG_IDX_WIDTH-1:0] REG_STABLE = 2'd0;
	localparam logic [REG_IDX_WIDTH-1:0] REG_SHORT = 2'd1;
	localparam logic [REG_IDX_WIDTH-1:0] REG_LONG = 2'd2;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_INJECT = 1'b1;

	typedef enum logic [1:0] {
		KIND_EVENT = 2'd0,
		KIND_ACCEPTED = 2'd1,
		KIND_REJECTED = 2'd2
	} kind_t;

	// one queued job: an inject verdict, or a set of flipped buttons
	typedef struct packed {
		kind_t kind;
		logic [IDX_WIDTH-1:0] btn;
		logic [RAW_WIDTH-1:0] flips;
		logic [RAW_WIDTH-1:0] levels;
	} mbd_entry_t;

endpackage

FILE: src/mbd_front.sv
// Front end: config registers, inject state and per-button debounce counters
module mbd_front import mbd_pkg::*; #(
	parameter int BUTTON_COUNT = DEF_BUTTON_COUNT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [REG_IDX_WIDTH-1:0] wr_index,
	input  logic [CFG_WIDTH-1:0]     wr_data,
	input  logic                     accept,
	input  logic                     opcode,
	input  logic [RAW_WIDTH-1:0]     raw_levels,
	input  logic [IDX_WIDTH-1:0]     inject_button,
	input  logic                     inject_long,
	output logic                     push,
	output mbd_entry_t               push_entry
);

	localparam int Lanes = (BUTTON_COUNT < RAW_WIDTH) ? BUTTON_COUNT : RAW_WIDTH;

	logic [CNT_WIDTH-1:0] stable_q;
	logic [DUR_WIDTH-1:0] short_q;
	logic [DUR_WIDTH-1:0] long_q;

	logic [RAW_WIDTH-1:0] lvl_q;
	logic [RAW_WIDTH-1:0] lvl_nxt;
	logic [CNT_WIDTH-1:0] cnt_q [Lanes];
	logic [CNT_WIDTH-1:0] cnt_nxt [Lanes];
	logic [CNT_WIDTH-1:0] cnt_inc [Lanes];
	logic [RAW_WIDTH-1:0] inj_mask_q;
	logic [DUR_WIDTH-1:0] inj_rem_q;
	logic                 inj_active;
	logic [RAW_WIDTH-1:0] eff;
	logic [RAW_WIDTH-1:0] flips;

	assign inj_active = (inj_rem_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= STABLE_RESET;
			short_q <= SHORT_RESET;
			long_q <= LONG_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_STABLE: stable_q <= wr_data[CNT_WIDTH-1:0];
				REG_SHORT: short_q <= wr_data[DUR_WIDTH-1:0];
				REG_LONG: long_q <= wr_data[DUR_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		eff = raw_levels | (inj_active ? inj_mask_q : '0);
		flips = '0;
		lvl_nxt = lvl_q;
		for (int i = 0; i < Lanes; i++) begin
			cnt_inc[i] = cnt_q[i] + 1'b1;
			if (eff[i] == lvl_q[i]) begin
				cnt_nxt[i] = '0;
			end else if (cnt_inc[i] >= stable_q) begin
				cnt_nxt[i] = '0;
				flips[i] = 1'b1;
				lvl_nxt[i] = ~lvl_q[i];
			end else begin
				cnt_nxt[i] = cnt_inc[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
			inj_mask_q <= '0;
			inj_rem_q <= '0;
			for (int i = 0; i < Lanes; i++) cnt_q[i] <= '0;
		end else if (accept) begin
			if (opcode == OP_INJECT) begin
				if (!inj_active) begin
					inj_mask_q <= RAW_WIDTH'(1) << inject_button;
					inj_rem_q <= inject_long ? long_q : short_q;
				end
			end else begin
				lvl_q <= lvl_nxt;
				for (int i = 0; i < Lanes; i++) cnt_q[i] <= cnt_nxt[i];
				if (inj_active) begin
					inj_rem_q <= inj_rem_q - 1'b1;
					if (inj_rem_q == DUR_WIDTH'(1)) inj_mask_q <= '0;
				end
			end
		end
	end

	always_comb begin
		push_entry.btn = inject_button;
		push_entry.flips = flips;
		push_entry.levels = lvl_nxt;
		if (opcode == OP_INJECT) begin
			push_entry.kind = inj_active ? KIND_REJECTED : KIND_ACCEPTED;
			push = accept;
		end else begin
			push_entry.kind = KIND_EVENT;
			push = accept && (flips != '0);
		end
	end

endmodule

FILE: src/mbd_queue.sv
// Short job queue between front and back end
module mbd_queue import mbd_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mbd_entry_t push_entry,
	input  logic       pop,
	output mbd_entry_t head,
	output logic       empty,
	output logic       full
);

	localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntWidth = $clog2(DEPTH + 1);

	mbd_entry_t          slot_q [DEPTH];
	logic [PtrWidth-1:0] wr_ptr_q;
	logic [PtrWidth-1:0] rd_ptr_q;
	logic [CntWidth-1:0] count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == CntWidth'(DEPTH));
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: src/mbd_back.sv
// Back end: serialises jobs into beats, one per cycle unless stalled
module mbd_back import mbd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mbd_entry_t           head,
	input  logic                 empty,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           kind,
	output logic [IDX_WIDTH-1:0] button_index,
	output logic                 pressed,
	output logic                 last
);

	logic [RAW_WIDTH-1:0] sent_q;
	logic [RAW_WIDTH-1:0] remaining;
	logic [RAW_WIDTH-1:0] sel_bit;
	logic [IDX_WIDTH-1:0] sel;
	logic                 last_evt;
	logic                 load;
	logic                 out_valid_q;
	logic [1:0]           kind_q;
	logic [IDX_WIDTH-1:0] idx_q;
	logic                 pressed_q;
	logic                 last_q;

	assign remaining = head.flips & ~sent_q;
	assign last_evt = ((remaining & (remaining - 1'b1)) == '0);

	always_comb begin
		sel = '0;
		for (int i = RAW_WIDTH - 1; i >= 0; i--) begin
			if (remaining[i]) sel = IDX_WIDTH'(i);
		end
	end

	assign sel_bit = RAW_WIDTH'(1) << sel;
	assign load = !empty && (!out_valid_q || !out_stall);
	assign pop = load && ((head.kind != KIND_EVENT) || last_evt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sent_q <= '0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (pop) sent_q <= '0;
			else if (load) sent_q <= sent_q | sel_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= head.kind;
			if (head.kind == KIND_EVENT) begin
				idx_q <= sel;
				pressed_q <= head.levels[sel];
				last_q <= last_evt;
			end else begin
				idx_q <= head.btn;
				pressed_q <= 1'b0;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign button_index = idx_q;
	assign pressed = pressed_q;
	assign last = last_q;

endmodule

FILE: src/multi_button_debouncer.sv
// Multi-button debouncer top level
// Input channel (in_valid / in_stall): one beat is a sample tick carrying raw
// button levels, or a request to inject a short or long virtual press.
// Output channel (out_valid / out_stall): one beat per result. A sample gives
// one up/down event per debounced flip, lowest button first, none if nothing
// flipped; an inject gives one accepted or rejected beat. last marks the final
// beat of an input item.
// Config port (wr_en / wr_index / wr_data): stable_samples, short and long
// press durations; the user must write them only while idle (unchecked).
// The first result of a beat passes the job queue slot, then the output
// register. One input beat per cycle while the job queue has room, one result
// beat per cycle while out_stall is low; a sample with n flips holds the back
// end for its n event beats before it takes the next job.
// A stalled output keeps its beat; the front keeps taking items until the
// job queue fills, then raises in_stall.
// Reset clears all debounced levels, counters and any injected press, and
// loads the default thresholds (20, 60, 400).
module multi_button_debouncer import mbd_pkg::*; #(
	parameter int BUTTON_COUNT = DEF_BUTTON_COUNT,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [REG_IDX_WIDTH-1:0] wr_index,
	input  logic [CFG_WIDTH-1:0]     wr_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic [RAW_WIDTH-1:0]     raw_levels,
	input  logic [IDX_WIDTH-1:0]     inject_button,
	input  logic                     inject_long,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               kind,
	output logic [IDX_WIDTH-1:0]     button_index,
	output logic                     pressed,
	output logic                     last
);

	logic       accept;
	logic       push;
	logic       pop;
	logic       empty;
	logic       full;
	mbd_entry_t push_entry;
	mbd_entry_t head;

	assign in_stall = full;
	assign accept = in_valid && !full;

	mbd_front #(
		.BUTTON_COUNT(BUTTON_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.accept(accept),
		.opcode(opcode),
		.raw_levels(raw_levels),
		.inject_button(inject_button),
		.inject_long(inject_long),
		.push(push),
		.push_entry(push_entry)
	);

	mbd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head(head),
		.empty(empty),
		.full(full)
	);

	mbd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.button_index(button_index),
		.pressed(pressed),
		.last(last)
	);

endmodule

FILE: src/mbd_checker.sv
// Port-level checker for the multi-button debouncer, bound to the top level
`include "multi_button_debouncer_macros.svh"

module mbd_checker import mbd_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [1:0]               kind,
	input logic [IDX_WIDTH-1:0]     button_index,
	input logic                     pressed,
	input logic                     last
);

	`MBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(button_index) && $stable(pressed) && $stable(last), "stalled output beat changed")
	`MBD_ASSERT_NOW(a_kind_legal, out_valid, kind == KIND_EVENT || kind == KIND_ACCEPTED || kind == KIND_REJECTED, "illegal result kind")
	`MBD_ASSERT_NOW(a_inject_last, out_valid && kind != KIND_EVENT, last && !pressed, "inject verdict not a single beat")
	`MBD_ASSERT_NEXT(a_event_order, out_valid && !out_stall && kind == KIND_EVENT && !last, out_valid && kind == KIND_EVENT && button_index > $past(button_index), "event beats out of button order")

endmodule

bind multi_button_debouncer mbd_checker u_mbd_checker (.*);

FILE: sim/tb_multi_button_debouncer.sv
// Testbench for the multi-button debouncer: directed and random beats checked against a predictor
`timescale 1ns / 100ps

module tb_multi_button_debouncer import mbd_pkg::*;;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int PIPE_FLUSH = 6;

	typedef struct packed {
		kind_t kind;
		logic [IDX_WIDTH-1:0] btn;
		logic down;
		logic tail;
	} event_t;

	class debounce_scoreboard;
		logic [CNT_WIDTH-1:0] thr;
		logic [DUR_WIDTH-1:0] short_len;
		logic [DUR_WIDTH-1:0] long_len;
		logic [RAW_WIDTH-1:0] levels;
		logic [CNT_WIDTH-1:0] miss_cnt [RAW_WIDTH];
		logic [RAW_WIDTH-1:0] press_mask;
		logic [DUR_WIDTH-1:0] press_left;
		event_t expected_events [$];
		int errors;

		function new();
			thr = STABLE_RESET;
			short_len = SHORT_RESET;
			long_len = LONG_RESET;
			levels = '0;
			foreach (miss_cnt[i])
				miss_cnt[i] = '0;
			press_mask = '0;
			press_left = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [REG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] data);
			case (idx)
				REG_STABLE: thr = data[CNT_WIDTH-1:0];
				REG_SHORT: short_len = data[DUR_WIDTH-1:0];
				REG_LONG: long_len = data[DUR_WIDTH-1:0];
				default: ;
			endcase
		endfunction

		function void add_item(logic op, logic [RAW_WIDTH-1:0] raw,
				logic [IDX_WIDTH-1:0] btn, logic lng);
			logic [RAW_WIDTH-1:0] lv;
			logic [RAW_WIDTH-1:0] flips;
			event_t e;
			int i;
			if (op == OP_INJECT) begin
				e.btn = btn;
				e.down = 1'b0;
				e.tail = 1'b1;
				if (press_left != '0) begin
					e.kind = KIND_REJECTED;
				end else begin
					e.kind = KIND_ACCEPTED;
					press_mask = 4'b0001 << btn;
					press_left = lng ? long_len : short_len;
				end
				expected_events.push_back(e);
				return;
			end
			lv = raw;
			if (press_left != '0) begin
				lv = lv | press_mask;
				press_left = press_left - 1'b1;
				if (press_left == '0)
					press_mask = '0;
			end
			flips = '0;
			for (i = 0; i < RAW_WIDTH; i++) begin
				if (lv[i] == levels[i]) begin
					miss_cnt[i] = '0;
				end else begin
					miss_cnt[i] = miss_cnt[i] + 8'd1;
					if (miss_cnt[i] >= thr) begin
						miss_cnt[i] = '0;
						levels[i] = ~levels[i];
						flips[i] = 1'b1;
					end
				end
			end
			for (i = 0; i < RAW_WIDTH; i++) begin
				if (flips[i]) begin
					e.kind = KIND_EVENT;
					e.btn = i[IDX_WIDTH-1:0];
					e.down = levels[i];
					e.tail = ((flips >> (i + 1)) == '0);
					expected_events.push_back(e);
				end
			end
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_event(logic [1:0] k, logic [IDX_WIDTH-1:0] b, logic p, logic l);
			event_t e;
			if (expected_events.size() == 0) begin
				report($sformatf("unexpected beat kind=%0d btn=%0d pressed=%0d last=%0d",
					k, b, p, l));
				return;
			end
			e = expected_events.pop_front();
			if (k !== e.kind || b !== e.btn || p !== e.down || l !== e.tail)
				report($sformatf("got kind=%0d btn=%0d pressed=%0d last=%0d, want %0d %0d %0d %0d",
					k, b, p, l, e.kind, e.btn, e.down, e.tail));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [REG_IDX_WIDTH-1:0] wr_index;
	logic [CFG_WIDTH-1:0] wr_data;
	logic in_valid;
	logic in_stall;
	logic opcode;
	logic [RAW_WIDTH-1:0] raw_levels;
	logic [IDX_WIDTH-1:0] inject_button;
	logic inject_long;
	logic out_valid;
	logic out_stall;
	logic [1:0] kind;
	logic [IDX_WIDTH-1:0] button_index;
	logic pressed;
	logic last;

	logic idle_in;
	logic idle_out;
	logic hold_req;
	int cfg_stable;
	int quiet_cycles;
	debounce_scoreboard sb;

	multi_button_debouncer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.raw_levels(raw_levels),
		.inject_button(inject_button),
		.inject_long(inject_long),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.button_index(button_index),
		.pressed(pressed),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_beat(logic op, logic [RAW_WIDTH-1:0] raw,
			logic [IDX_WIDTH-1:0] btn, logic lng);
		while (idle_in && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		raw_levels <= raw;
		inject_button <= btn;
		inject_long <= lng;
		do
			@(posedge clk);
		while (in_stall);
		sb.add_item(op, raw, btn, lng);
		@(negedge clk);
	endtask

	task automatic sample(logic [RAW_WIDTH-1:0] raw);
		send_beat(OP_SAMPLE, raw, 2'($urandom_range(3)), 1'($urandom_range(1)));
	endtask

	task automatic inject(logic [IDX_WIDTH-1:0] btn, logic lng);
		send_beat(OP_INJECT, 4'($urandom_range(15)), btn, lng);
	endtask

	// wait for every expected beat, let the pipe flush, then rewrite all registers
	task automatic set_thresholds(int s, int sh, int lg);
		in_valid <= 1'b0;
		while (sb.expected_events.size() != 0)
			@(negedge clk);
		repeat (PIPE_FLUSH) @(negedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_STABLE;
		wr_data <= CFG_WIDTH'(s);
		sb.write_reg(REG_STABLE, CFG_WIDTH'(s));
		@(negedge clk);
		wr_index <= REG_SHORT;
		wr_data <= CFG_WIDTH'(sh);
		sb.write_reg(REG_SHORT, CFG_WIDTH'(sh));
		@(negedge clk);
		wr_index <= REG_LONG;
		wr_data <= CFG_WIDTH'(lg);
		sb.write_reg(REG_LONG, CFG_WIDTH'(lg));
		@(negedge clk);
		wr_en <= 1'b0;
		cfg_stable = s;
		@(negedge clk);
	endtask

	// mostly steady runs with bounce, plus noise and injects
	task automatic random_phase(int n);
		logic [RAW_WIDTH-1:0] target;
		logic [RAW_WIDTH-1:0] lv;
		int run_left;
		int r;
		target = 4'($urandom_range(15));
		run_left = (cfg_stable < 1 ? 1 : cfg_stable) + $urandom_range(4);
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 10) begin
				inject(2'($urandom_range(3)), 1'($urandom_range(1)));
			end else if (r < 20) begin
				sample(4'($urandom_range(15)));
			end else begin
				lv = target;
				if ($urandom_range(9) == 0)
					lv = lv ^ 4'($urandom_range(15));
				sample(lv);
				run_left--;
				if (run_left <= 0) begin
					target = 4'($urandom_range(15));
					run_left = (cfg_stable < 1 ? 1 : cfg_stable) + $urandom_range(4);
				end
			end
		end
	endtask

	// receiver: random stall, one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall <= idle_out && ($urandom_range(99) < 31);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_event(kind, button_index, pressed, last);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_multi_button_debouncer NOT OK");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_STABLE;
		wr_data = '0;
		in_valid = 1'b0;
		opcode = OP_SAMPLE;
		raw_levels = '0;
		inject_button = '0;
		inject_long = 1'b0;
		idle_in = 1'b1;
		idle_out = 1'b1;
		hold_req = 1'b0;
		cfg_stable = STABLE_RESET;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_thresholds(1, 3, 5);
		sample(4'hF);
		sample(4'hF);
		sample(4'h0);
		inject(2'd3, 1'b1);
		inject(2'd1, 1'b0);
		repeat (6) sample(4'h0);
		inject(2'd2, 1'b0);
		sample(4'h5);
		sample(4'hA);
		sample(4'hA);
		sample(4'h0);

		// zero threshold and zero-length press
		set_thresholds(0, 0, 1);
		inject(2'd1, 1'b0);
		inject(2'd0, 1'b1);
		sample(4'h0);
		sample(4'h0);

		// lower the threshold under a running count
		set_thresholds(3, 1, 1);
		sample(4'h2);
		sample(4'h2);
		set_thresholds(1, 1, 1);
		sample(4'h2);
		sample(4'h0);

		hold_req = 1'b1;
		random_phase(80);
		set_thresholds(2, 4, 9);
		idle_in = 1'b0;
		idle_out = 1'b0;
		random_phase(70);
		idle_in = 1'b1;
		idle_out = 1'b1;
		set_thresholds(3, 12, 30);
		random_phase(70);
		set_thresholds(STABLE_RESET, SHORT_RESET, LONG_RESET);
		random_phase(126);
		set_thresholds(0, 3, 6);
		random_phase(70);
		set_thresholds(255, 65535, 65535);
		random_phase(40);

		in_valid <= 1'b0;
		while (sb.expected_events.size() != 0)
			@(negedge clk);
		repeat (PIPE_FLUSH) @(negedge clk);
		if (sb.expected_events.size() != 0)
			sb.report("expected beats left over");
		if (sb.errors == 0)
			$display("tb_multi_button_debouncer OK");
		else
			$display("tb_multi_button_debouncer NOT OK");
		$finish;
	end

endmodule
